// ----- rtl/core/fdsm_pkg.sv -----
// shared types, constants and name patterns of the fat directory scanner
`default_nettype none

package fdsm_pkg;

    localparam int NUM_DISK_SLOTS = 16;
    localparam int SLOT_COUNT     = NUM_DISK_SLOTS + 1;
    localparam int SLOT_W         = $clog2(SLOT_COUNT);
    localparam int QUEUE_DEPTH    = 4;
    localparam int QUEUE_AW       = $clog2(QUEUE_DEPTH);

    typedef enum logic [1:0] {
        OP_BYTE  = 2'd0,
        OP_READ  = 2'd1,
        OP_WRITE = 2'd2,
        OP_CLEAR = 2'd3
    } t_op;

    localparam logic [1:0] REG_RESERVED = 2'd0;
    localparam logic [1:0] REG_SPF      = 2'd1;
    localparam logic [1:0] REG_SPC      = 2'd2;

    localparam logic [15:0] RESERVED_RESET = 16'd32;
    localparam logic [27:0] SPF_RESET      = 28'd0;
    localparam logic [7:0]  SPC_RESET      = 8'd8;

    localparam logic [7:0] BYTE_FREE    = 8'h00;
    localparam logic [7:0] BYTE_DELETED = 8'hE5;
    localparam logic [7:0] ATTR_LFN     = 8'h0F;
    localparam int         ATTR_ARCHIVE = 5;
    localparam logic [7:0] LETTER_FIRST = 8'h41;

    localparam logic [4:0] OFF_FIRST   = 5'd0;
    localparam logic [4:0] OFF_LETTER  = 5'd4;
    localparam logic [4:0] OFF_ATTR    = 5'd11;
    localparam logic [4:0] OFF_CLH_LO  = 5'd20;
    localparam logic [4:0] OFF_CLH_HI  = 5'd21;
    localparam logic [4:0] OFF_CLL_LO  = 5'd26;
    localparam logic [4:0] OFF_CLL_HI  = 5'd27;
    localparam logic [4:0] OFF_SIZE_1  = 5'd29;
    localparam logic [4:0] OFF_SIZE_2  = 5'd30;
    localparam logic [4:0] OFF_SIZE_3  = 5'd31;

    typedef struct packed {
        t_op                op;
        logic [7:0]         dir_byte;
        logic               idx_ok;
        logic [SLOT_W-1:0]  slot;
        logic [31:0]        sector;
    } t_item;

    typedef struct packed {
        logic [15:0] reserved_sectors;
        logic [27:0] sectors_per_fat;
        logic [7:0]  sectors_per_cluster;
    } t_cfg;

    function automatic logic [7:0] disk_pat_byte(input logic [4:0] off);
        logic [7:0] c;
        case (off)
            5'd0:    c = 8'h44;
            5'd1:    c = 8'h49;
            5'd2:    c = 8'h53;
            5'd3:    c = 8'h4B;
            5'd8:    c = 8'h44;
            5'd9:    c = 8'h41;
            5'd10:   c = 8'h54;
            default: c = 8'h20;
        endcase
        return c;
    endfunction

    function automatic logic [7:0] cfg_pat_byte(input logic [4:0] off);
        logic [7:0] c;
        case (off)
            5'd0:    c = 8'h43;
            5'd1:    c = 8'h4F;
            5'd2:    c = 8'h4E;
            5'd3:    c = 8'h46;
            5'd4:    c = 8'h49;
            5'd5:    c = 8'h47;
            5'd8:    c = 8'h42;
            5'd9:    c = 8'h49;
            5'd10:   c = 8'h4E;
            default: c = 8'h20;
        endcase
        return c;
    endfunction

endpackage

`default_nettype wire

// ----- rtl/core/fdsm_front.sv -----
// input stage: accepts words, decodes the opcode and checks the slot index
`default_nettype none

module fdsm_front import fdsm_pkg::*; (
    input  wire logic        i_clk,
    input  wire logic        i_rst_n,
    input  wire logic        i_valid,
    input  wire logic [1:0]  i_opcode,
    input  wire logic [7:0]  i_dir_byte,
    input  wire logic [4:0]  i_disk_index,
    input  wire logic [31:0] i_sector_number,
    input  wire logic        i_q_full,
    output logic             o_stall,
    output logic             o_push,
    output t_item            o_item
);

    logic  r_valid;
    t_item r_item;
    t_item n_item;
    logic  w_accept;

    assign o_stall  = r_valid && i_q_full;
    assign o_push   = r_valid && !i_q_full;
    assign o_item   = r_item;
    assign w_accept = i_valid && !o_stall;

    always_comb begin
        n_item.op       = t_op'(i_opcode);
        n_item.dir_byte = i_dir_byte;
        n_item.idx_ok   = i_disk_index < 5'(SLOT_COUNT);
        n_item.slot     = n_item.idx_ok ? i_disk_index[SLOT_W-1:0] : '0;
        n_item.sector   = i_sector_number;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= 1'b0;
        end else if (!o_stall) begin
            r_valid <= i_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_accept) begin
            r_item <= n_item;
        end
    end

endmodule

`default_nettype wire

// ----- rtl/core/fdsm_queue.sv -----
// short word queue between the input stage and the scanner
`default_nettype none

module fdsm_queue import fdsm_pkg::*; (
    input  wire logic  i_clk,
    input  wire logic  i_rst_n,
    input  wire logic  i_push,
    input  wire t_item i_item,
    output logic       o_full,
    output logic       o_valid,
    output t_item      o_item,
    input  wire logic  i_pop
);

    t_item               r_mem [QUEUE_DEPTH];
    logic [QUEUE_AW-1:0] r_wr;
    logic [QUEUE_AW-1:0] r_rd;
    logic [QUEUE_AW:0]   r_count;

    assign o_full  = r_count == (QUEUE_AW+1)'(QUEUE_DEPTH);
    assign o_valid = r_count != '0;
    assign o_item  = r_mem[r_rd];

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr    <= '0;
            r_rd    <= '0;
            r_count <= '0;
        end else begin
            if (i_push) begin
                r_wr <= r_wr + 1'b1;
            end
            if (i_pop) begin
                r_rd <= r_rd + 1'b1;
            end
            case ({i_push, i_pop})
                2'b10:   r_count <= r_count + 1'b1;
                2'b01:   r_count <= r_count - 1'b1;
                default: r_count <= r_count;
            endcase
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_push) begin
            r_mem[r_wr] <= i_item;
        end
    end

endmodule

`default_nettype wire

// ----- rtl/core/fdsm_back.sv -----
// directory byte scanner, slot table and access translation with output register
`default_nettype none

module fdsm_back import fdsm_pkg::*; (
    input  wire logic         i_clk,
    input  wire logic         i_rst_n,
    input  wire t_cfg         i_cfg,
    input  wire logic         i_q_valid,
    input  wire t_item        i_item,
    output logic              o_pop,
    output logic              o_valid,
    input  wire logic         i_stall,
    output logic [31:0]       o_lba,
    output logic              o_ok,
    output logic              o_is_write,
    output logic [16:0]       o_active_mask
);

    logic [8:0]  r_pos;
    logic        r_skip;
    logic        r_ign;
    logic        r_dmatch;
    logic        r_cmatch;
    logic [7:0]  r_letter;
    logic [15:0] r_clh;
    logic [15:0] r_cll;
    logic [22:0] r_blocks;

    logic [8:0]  n_pos;
    logic        n_skip;
    logic        n_ign;
    logic        n_dmatch;
    logic        n_cmatch;
    logic [7:0]  n_letter;
    logic [15:0] n_clh;
    logic [15:0] n_cll;
    logic [22:0] n_blocks;

    logic [31:0]           r_lba [SLOT_COUNT];
    logic [22:0]           r_cnt [SLOT_COUNT];
    logic [SLOT_COUNT-1:0] r_active;

    logic [31:0] r_base;
    logic [31:0] r_prod;

    logic        r_out_valid;
    logic [31:0] r_out_lba;
    logic        r_out_ok;
    logic        r_out_wr;
    logic [16:0] r_out_mask;

    logic              w_access;
    logic              w_out_free;
    logic              w_byte;
    logic              w_clear;
    logic [4:0]        w_off;
    logic [7:0]        w_b;
    logic              w_commit;
    logic [7:0]        w_letter_off;
    logic              w_disk_ok;
    logic [SLOT_W-1:0] w_slot;
    logic [31:0]       w_start;
    logic [39:0]       w_mul;
    logic [31:0]       w_cm2;
    logic [31:0]       w_sel_lba;
    logic [22:0]       w_sel_cnt;
    logic              w_ok;

    assign w_access   = (i_item.op == OP_READ) || (i_item.op == OP_WRITE);
    assign w_out_free = !r_out_valid || !i_stall;
    assign o_pop      = i_q_valid && (!w_access || w_out_free);
    assign w_byte     = o_pop && (i_item.op == OP_BYTE);
    assign w_clear    = o_pop && (i_item.op == OP_CLEAR);
    assign w_off      = r_pos[4:0];
    assign w_b        = i_item.dir_byte;

    // entry name, attribute, cluster and size fields
    always_comb begin
        n_pos    = r_pos + 1'b1;
        n_skip   = r_skip;
        n_ign    = r_ign;
        n_dmatch = r_dmatch;
        n_cmatch = r_cmatch;
        n_letter = r_letter;
        n_clh    = r_clh;
        n_cll    = r_cll;
        n_blocks = r_blocks;
        w_commit = 1'b0;
        if (!r_skip) begin
            if (w_off == OFF_FIRST) begin
                if (w_b == BYTE_FREE) begin
                    n_skip = 1'b1;
                end else begin
                    n_ign    = w_b == BYTE_DELETED;
                    n_dmatch = w_b == disk_pat_byte(OFF_FIRST);
                    n_cmatch = w_b == cfg_pat_byte(OFF_FIRST);
                    n_letter = '0;
                    n_clh    = '0;
                    n_cll    = '0;
                    n_blocks = '0;
                end
            end else if (!r_ign) begin
                if (w_off < OFF_ATTR) begin
                    if (w_off == OFF_LETTER) begin
                        n_letter = w_b;
                    end else if (w_b != disk_pat_byte(w_off)) begin
                        n_dmatch = 1'b0;
                    end
                    if (w_b != cfg_pat_byte(w_off)) begin
                        n_cmatch = 1'b0;
                    end
                end else begin
                    case (w_off)
                        OFF_ATTR: begin
                            if (w_b == ATTR_LFN || !w_b[ATTR_ARCHIVE]) begin
                                n_ign = 1'b1;
                            end
                        end
                        OFF_CLH_LO: n_clh[7:0]  = w_b;
                        OFF_CLH_HI: n_clh[15:8] = w_b;
                        OFF_CLL_LO: n_cll[7:0]  = w_b;
                        OFF_CLL_HI: n_cll[15:8] = w_b;
                        OFF_SIZE_1: n_blocks = {16'd0, w_b[7:1]};
                        OFF_SIZE_2: n_blocks = r_blocks | {8'd0, w_b, 7'd0};
                        OFF_SIZE_3: begin
                            n_blocks = r_blocks | {w_b, 15'd0};
                            w_commit = 1'b1;
                        end
                        default: ;
                    endcase
                end
            end
        end
        if (r_pos == 9'd511) begin
            n_skip = 1'b0;
        end
    end

    assign w_letter_off = r_letter - LETTER_FIRST;
    assign w_disk_ok    = r_dmatch && (r_letter >= LETTER_FIRST)
                          && (w_letter_off < 8'(NUM_DISK_SLOTS));
    assign w_slot       = w_disk_ok ? w_letter_off[SLOT_W-1:0] : SLOT_W'(NUM_DISK_SLOTS);
    assign w_start      = r_base + r_prod;

    // cluster registers settle at byte 27, the product is ready well before byte 31
    assign w_cm2 = {r_clh, r_cll} - 32'd2;
    assign w_mul = {32'd0, i_cfg.sectors_per_cluster} * {8'd0, w_cm2};

    always_ff @(posedge i_clk) begin
        r_base <= {16'd0, i_cfg.reserved_sectors} + {3'd0, i_cfg.sectors_per_fat, 1'b0};
        r_prod <= w_mul[31:0];
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_pos    <= '0;
            r_skip   <= 1'b0;
            r_ign    <= 1'b0;
            r_dmatch <= 1'b0;
            r_cmatch <= 1'b0;
            r_letter <= '0;
            r_clh    <= '0;
            r_cll    <= '0;
            r_blocks <= '0;
        end else if (w_byte) begin
            r_pos    <= n_pos;
            r_skip   <= n_skip;
            r_ign    <= n_ign;
            r_dmatch <= n_dmatch;
            r_cmatch <= n_cmatch;
            r_letter <= n_letter;
            r_clh    <= n_clh;
            r_cll    <= n_cll;
            r_blocks <= n_blocks;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_active <= '0;
        end else if (w_clear) begin
            r_active <= '0;
        end else if (w_byte && w_commit && (w_disk_ok || (!r_dmatch && r_cmatch))) begin
            r_active[w_slot] <= w_start != 32'd0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_byte && w_commit && (w_disk_ok || (!r_dmatch && r_cmatch))) begin
            r_lba[w_slot] <= w_start;
            r_cnt[w_slot] <= n_blocks;
        end
    end

    // access translation
    assign w_sel_lba = r_lba[i_item.slot];
    assign w_sel_cnt = r_cnt[i_item.slot];
    assign w_ok      = i_item.idx_ok && r_active[i_item.slot]
                       && (i_item.sector < {9'd0, w_sel_cnt});

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (w_out_free) begin
            r_out_valid <= o_pop && w_access;
        end
    end

    always_ff @(posedge i_clk) begin
        if (o_pop && w_access) begin
            r_out_lba  <= w_ok ? (w_sel_lba + i_item.sector) : 32'd0;
            r_out_ok   <= w_ok;
            r_out_wr   <= i_item.op == OP_WRITE;
            r_out_mask <= 17'(r_active);
        end
    end

    assign o_valid       = r_out_valid;
    assign o_lba         = r_out_lba;
    assign o_ok          = r_out_ok;
    assign o_is_write    = r_out_wr;
    assign o_active_mask = r_out_mask;

endmodule

`default_nettype wire

// ----- rtl/core/fat_dir_scan_disk_map.sv -----
// top level of the fat directory scanner and disk slot map
//
// channel  direction  handshake           payload
// input    in         i_valid / o_stall   i_opcode i_dir_byte i_disk_index i_sector_number
// output   out        o_valid / i_stall   o_lba o_ok o_is_write o_active_mask
// config   in         apb psel / penable  paddr pwdata prdata
//
// one word per cycle sustained while the output is not stalled: input register, four-entry queue, scanner with table
// an access result passes the input register, the queue and the output register, held further under output stall
// synchronous reset clears the queue, scan state and slot valid bits, loads register defaults
// a stalled output holds its word and backs words up behind the next access word into the queue, then the input
`default_nettype none

module fat_dir_scan_disk_map import fdsm_pkg::*; (
    input  wire logic        i_clk,
    input  wire logic        i_rst_n,
    input  wire logic        i_valid,
    output logic             o_stall,
    input  wire logic [1:0]  i_opcode,
    input  wire logic [7:0]  i_dir_byte,
    input  wire logic [4:0]  i_disk_index,
    input  wire logic [31:0] i_sector_number,
    output logic             o_valid,
    input  wire logic        i_stall,
    output logic [31:0]      o_lba,
    output logic             o_ok,
    output logic             o_is_write,
    output logic [16:0]      o_active_mask,
    input  wire logic        psel,
    input  wire logic        penable,
    input  wire logic        pwrite,
    input  wire logic [3:0]  paddr,
    input  wire logic [31:0] pwdata,
    output logic [31:0]      prdata,
    output logic             pready
);

    t_cfg  r_cfg;
    logic  w_push;
    t_item w_front_item;
    logic  w_q_full;
    logic  w_q_valid;
    t_item w_q_item;
    logic  w_pop;

    assign pready = 1'b1;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cfg.reserved_sectors    <= RESERVED_RESET;
            r_cfg.sectors_per_fat     <= SPF_RESET;
            r_cfg.sectors_per_cluster <= SPC_RESET;
        end else if (psel && penable && pwrite && pready) begin
            case (paddr[3:2])
                REG_RESERVED: r_cfg.reserved_sectors    <= pwdata[15:0];
                REG_SPF:      r_cfg.sectors_per_fat     <= pwdata[27:0];
                REG_SPC:      r_cfg.sectors_per_cluster <= pwdata[7:0];
                default: ;
            endcase
        end
    end

    always_comb begin
        case (paddr[3:2])
            REG_RESERVED: prdata = {16'd0, r_cfg.reserved_sectors};
            REG_SPF:      prdata = {4'd0, r_cfg.sectors_per_fat};
            REG_SPC:      prdata = {24'd0, r_cfg.sectors_per_cluster};
            default:      prdata = 32'd0;
        endcase
    end

    fdsm_front u_front (
        .i_clk           (i_clk),
        .i_rst_n         (i_rst_n),
        .i_valid         (i_valid),
        .i_opcode        (i_opcode),
        .i_dir_byte      (i_dir_byte),
        .i_disk_index    (i_disk_index),
        .i_sector_number (i_sector_number),
        .i_q_full        (w_q_full),
        .o_stall         (o_stall),
        .o_push          (w_push),
        .o_item          (w_front_item)
    );

    fdsm_queue u_queue (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_push  (w_push),
        .i_item  (w_front_item),
        .o_full  (w_q_full),
        .o_valid (w_q_valid),
        .o_item  (w_q_item),
        .i_pop   (w_pop)
    );

    fdsm_back u_back (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .i_cfg         (r_cfg),
        .i_q_valid     (w_q_valid),
        .i_item        (w_q_item),
        .o_pop         (w_pop),
        .o_valid       (o_valid),
        .i_stall       (i_stall),
        .o_lba         (o_lba),
        .o_ok          (o_ok),
        .o_is_write    (o_is_write),
        .o_active_mask (o_active_mask)
    );

endmodule

`default_nettype wire

// ----- rtl/core/fdsm_checker.sv -----
// port-level checks of the fat directory scanner and their bind to the top level
`default_nettype none

module fdsm_checker (
    input wire logic        i_clk,
    input wire logic        i_rst_n,
    input wire logic        o_stall,
    input wire logic        o_valid,
    input wire logic        i_stall,
    input wire logic [31:0] o_lba,
    input wire logic        o_ok,
    input wire logic [16:0] o_active_mask
);

    a_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid && i_stall |=> o_valid && $stable(o_lba) && $stable(o_ok))
        else $error("stalled result word changed");

    a_refused_zero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid && !o_ok |-> o_lba == 32'd0)
        else $error("refused access with nonzero lba");

    a_ok_active: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid && o_ok |-> o_active_mask != 17'd0)
        else $error("granted access with empty active mask");

    a_reset: assert property (@(posedge i_clk)
        !i_rst_n |=> !o_valid && !o_stall)
        else $error("handshake outputs not cleared by reset");

endmodule

bind fat_dir_scan_disk_map fdsm_checker u_fdsm_checker (
    .i_clk         (i_clk),
    .i_rst_n       (i_rst_n),
    .o_stall       (o_stall),
    .o_valid       (o_valid),
    .i_stall       (i_stall),
    .o_lba         (o_lba),
    .o_ok          (o_ok),
    .o_active_mask (o_active_mask)
);

`default_nettype wire
